### design/dwpp_pkg.sv
package dwpp_pkg;

  // Width of the sum field on the result channel
  localparam int unsigned SUM_OUT_W = 18;

  // Walk sequencer states
  typedef enum logic [1:0] {
    WS_IDLE,
    WS_START,
    WS_DIV,
    WS_DONE
  } walk_state_t;

  // Status from the serial divider back to the walk sequencer
  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_stat_t;

  // Finished result handed from the walk sequencer to the output register
  typedef struct packed {
    logic                 prime_flag;
    logic                 perfect_flag;
    logic [SUM_OUT_W-1:0] sum;
  } walk_res_t;

endpackage

### design/dwpp_div.sv
module dwpp_div import dwpp_pkg::*; #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output div_stat_t             stat
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] quo_r, quo_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   diff;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign trial = {rem_r, quo_r[VALUE_BITS-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      // Load the dividend into the shift register and clear the remainder
      quo_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Advance one bit per cycle
      quo_nxt = {quo_r[VALUE_BITS-2:0], 1'b0};
      rem_nxt = diff[VALUE_BITS] ? trial[VALUE_BITS-1:0] : diff[VALUE_BITS-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.done     = done_r;
  assign stat.rem_zero = (rem_r == '0);

endmodule

### design/dwpp_walk.sv
module dwpp_walk import dwpp_pkg::*; #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [VALUE_BITS-1:0] in_number,
  output logic                  in_stall,
  output logic                  div_go,
  output logic [VALUE_BITS-1:0] div_dividend,
  output logic [VALUE_BITS-1:0] div_divisor,
  input  div_stat_t             div_stat,
  output logic                  res_valid,
  output walk_res_t             res,
  input  logic                  res_take
);

  // Proper divisor sum stays below 8n for any width up to 32 bits
  localparam int unsigned ACC_W = (VALUE_BITS + 3 > SUM_OUT_W) ? VALUE_BITS + 3 : SUM_OUT_W;

  walk_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] n_r, n_nxt;
  logic [VALUE_BITS-1:0] d_r, d_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic                  found_r, found_nxt;
  logic                  neg_r, neg_nxt;

  logic                  accept;
  logic                  in_neg;
  logic                  in_long;
  logic                  last_trial;

  assign accept     = in_valid && (state_r == WS_IDLE);
  assign in_neg     = in_number[VALUE_BITS-1];
  assign in_long    = !in_neg && (in_number[VALUE_BITS-1:1] != '0);
  assign last_trial = ((d_r + 1'b1) == n_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      WS_IDLE: begin
        if (in_valid) state_nxt = in_long ? WS_START : WS_DONE;
      end
      WS_START: state_nxt = WS_DIV;
      WS_DIV: begin
        if (div_stat.done) state_nxt = last_trial ? WS_DONE : WS_START;
      end
      WS_DONE: begin
        if (res_take) state_nxt = WS_IDLE;
      end
      default: state_nxt = WS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall  = 1'b1;
    div_go    = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      WS_IDLE:  in_stall  = 1'b0;
      WS_START: div_go    = 1'b1;
      WS_DIV:   ;
      WS_DONE:  res_valid = 1'b1;
      default:  ;
    endcase
  end

  // Datapath: capture the number, advance the trial divisor, accumulate
  always_comb begin
    n_nxt     = n_r;
    d_nxt     = d_r;
    acc_nxt   = acc_r;
    found_nxt = found_r;
    neg_nxt   = neg_r;
    if (accept) begin
      neg_nxt   = in_neg;
      n_nxt     = in_neg ? '0 : in_number;
      d_nxt     = VALUE_BITS'(1);
      acc_nxt   = '0;
      found_nxt = 1'b0;
    end else if ((state_r == WS_DIV) && div_stat.done) begin
      if (div_stat.rem_zero) begin
        acc_nxt = acc_r + {{(ACC_W-VALUE_BITS){1'b0}}, d_r};
        if (d_r[VALUE_BITS-1:1] != '0) found_nxt = 1'b1;
      end
      if (!last_trial) d_nxt = d_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= WS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    acc_r   <= acc_nxt;
    found_r <= found_nxt;
    neg_r   <= neg_nxt;
  end

  assign div_dividend = n_r;
  assign div_divisor  = d_r;

  assign res.prime_flag   = !found_r;
  assign res.perfect_flag = !neg_r && (acc_r == {{(ACC_W-VALUE_BITS){1'b0}}, n_r});
  assign res.sum          = acc_r[SUM_OUT_W-1:0];

endmodule

### design/divisor_walk_prime_perfect_test.sv
// Trial-division primality and perfect-number test.
//
// Input channel (in_valid / in_stall / in_number): one signed number per
// transaction. in_stall is high while a number is being worked on or its
// result has not yet moved to the output register.
// Result channel (out_valid / out_stall / out_prime_flag / out_perfect_flag /
// out_proper_divisor_sum): one result per number, held in an output register.
//
// Operation: every divisor 1..n-1 is tried in turn with a bit-serial remainder
// unit, each trial framed by the WS_START and WS_DIV states of the walk
// sequencer. Numbers below two (negative ones included) skip the trials and
// go straight to the result. One number is worked on at a time; the next is
// taken once the result has moved to the output register.
//
// Reset (rst_n low, synchronous) empties the block: no result pending and the
// input open. While out_stall is high the result holds and a finished next
// result waits inside the block.
module divisor_walk_prime_perfect_test import dwpp_pkg::*; #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [VALUE_BITS-1:0] in_number,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_prime_flag,
  output logic                        out_perfect_flag,
  output logic [SUM_OUT_W-1:0]        out_proper_divisor_sum
);

  logic                  div_go;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] div_divisor;
  div_stat_t             div_stat;
  logic                  res_valid;
  walk_res_t             res;
  logic                  res_take;

  logic                  out_valid_r, out_valid_nxt;
  walk_res_t             out_res_r, out_res_nxt;

  dwpp_walk #(.VALUE_BITS(VALUE_BITS)) u_walk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_number    (in_number),
    .in_stall     (in_stall),
    .div_go       (div_go),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_stat     (div_stat),
    .res_valid    (res_valid),
    .res          (res),
    .res_take     (res_take)
  );

  dwpp_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat)
  );

  // Move a finished result into the output register when it is free
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_prime_flag         = out_res_r.prime_flag;
  assign out_perfect_flag       = out_res_r.perfect_flag;
  assign out_proper_divisor_sum = out_res_r.sum;

endmodule

### design/dwpp_chk.sv
module dwpp_chk import dwpp_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic                 out_prime_flag,
  input logic                 out_perfect_flag,
  input logic [SUM_OUT_W-1:0] out_proper_divisor_sum
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_prime_flag) &&
      $stable(out_perfect_flag) && $stable(out_proper_divisor_sum))
    else $error("stalled result changed");

  // One number at a time: input closes right after a transaction
  a_in_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transaction");

  // A prime has 1 as its only proper divisor
  a_prime_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_prime_flag |-> out_proper_divisor_sum <= SUM_OUT_W'(1))
    else $error("prime flagged with divisor sum above one");

  // A perfect number with a nonzero sum is never prime
  a_perfect_prime: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_perfect_flag && (out_proper_divisor_sum != '0) |-> !out_prime_flag)
    else $error("perfect number flagged prime");

endmodule

bind divisor_walk_prime_perfect_test dwpp_chk u_dwpp_chk (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_valid               (in_valid),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_prime_flag         (out_prime_flag),
  .out_perfect_flag       (out_perfect_flag),
  .out_proper_divisor_sum (out_proper_divisor_sum)
);
